[sv/abkf_pkg.sv]
// Shared constants, register codes and saturation helper of the angle/bias Kalman filter.
// No dependencies; every other file imports this package.
package abkf_pkg;

    localparam int AXES_DEF   = 2;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_ANGLE_Q   = 2'd1,
        CFG_BIAS_Q    = 2'd2,
        CFG_MEAS_R    = 2'd3
    } t_cfg_idx;

    localparam logic [DT_W-1:0]   DT_RST      = 24'd83886;
    localparam logic [DATA_W-1:0] ANGLE_Q_RST = 32'd268435;
    localparam logic [DATA_W-1:0] BIAS_Q_RST  = 32'd805306;
    localparam logic [DATA_W-1:0] MEAS_R_RST  = 32'd134217728;
    localparam logic signed [DATA_W-1:0] ONE_Q4_28 = 32'sd268435456;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [66:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 67'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -67'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/abkf_if.sv]
// Valid/ready channel interfaces for the filter's input and result beats.
// Depends on abkf_pkg.
interface abkf_in_if;
    import abkf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     axis;
    logic signed [DATA_W-1:0] measured_angle;
    logic signed [DATA_W-1:0] rate;
    modport source(output valid, axis, measured_angle, rate, input ready);
    modport sink(input valid, axis, measured_angle, rate, output ready);
endinterface

interface abkf_out_if;
    import abkf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     axis_out;
    logic signed [DATA_W-1:0] angle_estimate;
    logic signed [DATA_W-1:0] bias_estimate;
    modport source(output valid, axis_out, angle_estimate, bias_estimate, input ready);
    modport sink(input valid, axis_out, angle_estimate, bias_estimate, output ready);
endinterface

[sv/angle_bias_kalman_filter.sv]
// Two-state tilt angle / gyro bias Kalman filter, one state set per axis.
// Depends on abkf_pkg and abkf_if; one shared multiplier and a radix-2 divider.
//
//   channel    | dir | handshake     | payload
//   i_in_ch    | in  | valid/ready   | axis, measured_angle, rate
//   o_out_ch   | out | valid/ready   | axis_out, angle_estimate, bias_estimate
//   i_cfg_*    | in  | write enable  | i_cfg_idx, i_cfg_data
//
// A beat runs from accept to result as ten multiply/accumulate steps on the shared
// multiplier plus two gain divisions on the one-bit-per-cycle divider; the divisions
// are skipped, and both gains are zero, when the innovation variance is not positive.
// Reset is synchronous; it restores registers and all axis states at once.
// A finished result waits in the output register; the next beat is taken meanwhile,
// and only the final write-back waits for a free output register.
module angle_bias_kalman_filter #(
    parameter int AXES = abkf_pkg::AXES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    abkf_in_if.sink                           i_in_ch,
    abkf_out_if.source                        o_out_ch,
    input  logic                              i_cfg_we,
    input  logic [abkf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [abkf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import abkf_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_PREP, S_DSET, S_DIV, S_DFIN, S_WB
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG_P, OP_CAA_P, OP_CAB_P, OP_CBB_P,
        OP_CBA_C, OP_CBB_C, OP_CAA_C, OP_CAB_C, OP_ANG_C, OP_BIAS_C
    } t_op;

    logic [DT_W-1:0]   r_dt;
    logic [DATA_W-1:0] r_qa;
    logic [DATA_W-1:0] r_qb;
    logic [DATA_W-1:0] r_r;

    logic signed [DATA_W-1:0] r_ang_st [AXES];
    logic signed [DATA_W-1:0] r_bias_st[AXES];
    logic signed [DATA_W-1:0] r_p00_st [AXES];
    logic signed [DATA_W-1:0] r_p01_st [AXES];
    logic signed [DATA_W-1:0] r_p10_st [AXES];
    logic signed [DATA_W-1:0] r_p11_st [AXES];

    t_state r_state;
    t_op    r_op;
    logic   [AW-1:0] r_a;
    logic   r_axin;
    logic signed [DATA_W-1:0] r_meas, r_rate, r_ang, r_bias;
    logic signed [DATA_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [DATA_W-1:0] r_err, r_k0, r_k1;
    logic signed [33:0] r_e;
    logic signed [65:0] r_prod;
    logic        r_dsel, r_dneg, r_dovf;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [4:0]  r_cnt;

    logic                     r_ov;
    logic                     r_o_axis;
    logic signed [DATA_W-1:0] r_o_ang, r_o_bias;

    logic [AW-1:0]            w_a_in;
    logic signed [33:0]       m_a;
    logic signed [31:0]       m_b;
    logic                     m_sh24, m_sub;
    logic signed [DATA_W-1:0] m_tgt;
    logic signed [66:0]       w_rnd, w_rs, w_sum, w_sum2;
    logic signed [DATA_W-1:0] w_new, w_new2;
    logic signed [DATA_W-1:0] w_num;
    logic [31:0]              w_mag;
    logic [63:0]              w_dvd;
    logic [33:0]              w_t;
    logic                     w_ge;
    logic [31:0]              w_qe;
    logic signed [DATA_W-1:0] w_gain;

    assign w_a_in = (AXES > 1) ? AW'(i_in_ch.axis) : '0;
    assign i_in_ch.ready = (r_state == S_IDLE);

    assign o_out_ch.valid          = r_ov;
    assign o_out_ch.axis_out       = r_o_axis;
    assign o_out_ch.angle_estimate = r_o_ang;
    assign o_out_ch.bias_estimate  = r_o_bias;

    always_comb begin
        m_a    = '0;
        m_b    = signed'({8'd0, r_dt});
        m_sh24 = 1'b1;
        m_sub  = 1'b0;
        m_tgt  = r_ang;
        unique case (r_op)
            OP_ANG_P: begin
                m_a = 34'(r_rate) - 34'(r_bias);
            end
            OP_CAA_P: begin
                m_a   = signed'({2'b00, r_qa}) - 34'(r_p01) - 34'(r_p10);
                m_tgt = r_p00;
            end
            OP_CAB_P: begin
                m_a   = 34'(r_p11);
                m_sub = 1'b1;
                m_tgt = r_p01;
            end
            OP_CBB_P: begin
                m_a   = signed'({2'b00, r_qb});
                m_tgt = r_p11;
            end
            OP_CBA_C: begin
                m_a = 34'(r_p00); m_b = r_k1; m_sh24 = 1'b0; m_sub = 1'b1; m_tgt = r_p10;
            end
            OP_CBB_C: begin
                m_a = 34'(r_p01); m_b = r_k1; m_sh24 = 1'b0; m_sub = 1'b1; m_tgt = r_p11;
            end
            OP_CAA_C: begin
                m_a = 34'(r_p00); m_b = r_k0; m_sh24 = 1'b0; m_sub = 1'b1; m_tgt = r_p00;
            end
            OP_CAB_C: begin
                m_a = 34'(r_p01); m_b = r_k0; m_sh24 = 1'b0; m_sub = 1'b1; m_tgt = r_p01;
            end
            OP_ANG_C: begin
                m_a = 34'(r_err); m_b = r_k0; m_sh24 = 1'b0; m_tgt = r_ang;
            end
            OP_BIAS_C: begin
                m_a = 34'(r_err); m_b = r_k1; m_sh24 = 1'b0; m_tgt = r_bias;
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    always_comb begin
        w_rnd  = 67'(r_prod) + (m_sh24 ? 67'sd8388608 : 67'sd536870912);
        w_rs   = m_sh24 ? (w_rnd >>> 24) : (w_rnd >>> 30);
        w_sum  = m_sub ? (67'(m_tgt) - w_rs) : (67'(m_tgt) + w_rs);
        w_sum2 = 67'(r_p10) - w_rs;
        w_new  = sat32(w_sum);
        w_new2 = sat32(w_sum2);
    end

    always_comb begin
        w_num = r_dsel ? r_p10 : r_p00;
        w_mag = w_num[31] ? 32'(-33'(w_num)) : 32'(w_num);
        w_dvd = {2'b00, w_mag, 30'd0} + 64'(r_e[32:1]);
        w_t   = {r_rem, r_quo[31]};
        w_ge  = (w_t >= {1'b0, r_e[32:0]});
        w_qe  = (r_dovf || (r_quo > 32'h80000000)) ? 32'h80000000 : r_quo;
        if (r_dneg) begin
            w_gain = signed'(32'(33'd0 - 33'(w_qe)));
        end else if (r_dovf || r_quo[31]) begin
            w_gain = 32'sh7FFFFFFF;
        end else begin
            w_gain = signed'(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RST;
            r_qa <= ANGLE_Q_RST;
            r_qb <= BIAS_Q_RST;
            r_r  <= MEAS_R_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP: r_dt <= i_cfg_data[DT_W-1:0];
                CFG_ANGLE_Q:   r_qa <= i_cfg_data;
                CFG_BIAS_Q:    r_qb <= i_cfg_data;
                CFG_MEAS_R:    r_r  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ANG_P;
            r_ov    <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_ang_st[i]  <= '0;
                r_bias_st[i] <= '0;
                r_p00_st[i]  <= ONE_Q4_28;
                r_p01_st[i]  <= '0;
                r_p10_st[i]  <= '0;
                r_p11_st[i]  <= ONE_Q4_28;
            end
        end else begin
            if (r_state == S_WB && (!r_ov || o_out_ch.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_ch.valid) begin
                        r_axin  <= i_in_ch.axis;
                        r_a     <= w_a_in;
                        r_meas  <= i_in_ch.measured_angle;
                        r_rate  <= i_in_ch.rate;
                        r_ang   <= r_ang_st[w_a_in];
                        r_bias  <= r_bias_st[w_a_in];
                        r_p00   <= r_p00_st[w_a_in];
                        r_p01   <= r_p01_st[w_a_in];
                        r_p10   <= r_p10_st[w_a_in];
                        r_p11   <= r_p11_st[w_a_in];
                        r_op    <= OP_ANG_P;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= m_a * m_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    unique case (r_op)
                        OP_ANG_P, OP_ANG_C:           r_ang  <= w_new;
                        OP_CAA_P, OP_CAA_C:           r_p00  <= w_new;
                        OP_CAB_C:                     r_p01  <= w_new;
                        OP_CBB_P, OP_CBB_C:           r_p11  <= w_new;
                        OP_CBA_C:                     r_p10  <= w_new;
                        OP_BIAS_C:                    r_bias <= w_new;
                        OP_CAB_P: begin
                            r_p01 <= w_new;
                            r_p10 <= w_new2;
                        end
                        default: r_ang <= r_ang;
                    endcase
                    priority if (r_op == OP_CBB_P) begin
                        r_state <= S_PREP;
                    end else if (r_op == OP_BIAS_C) begin
                        r_state <= S_WB;
                    end else begin
                        r_op    <= t_op'(r_op + 4'd1);
                        r_state <= S_MUL;
                    end
                end
                S_PREP: begin
                    r_err   <= sat32(67'(r_meas) - 67'(r_ang));
                    r_e     <= signed'({2'b00, r_r}) + 34'(r_p00);
                    r_dsel  <= 1'b0;
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    if (r_e <= 34'sd0) begin
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_op    <= OP_CBA_C;
                        r_state <= S_MUL;
                    end else begin
                        r_dneg  <= w_num[31];
                        r_dovf  <= ({1'b0, w_dvd[63:32]} >= r_e[32:0]);
                        r_rem   <= {1'b0, w_dvd[63:32]};
                        r_quo   <= w_dvd[31:0];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 33'(w_t - {1'b0, r_e[32:0]}) : w_t[32:0];
                    r_quo <= {r_quo[30:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (r_dsel) begin
                        r_k1    <= w_gain;
                        r_op    <= OP_CBA_C;
                        r_state <= S_MUL;
                    end else begin
                        r_k0    <= w_gain;
                        r_dsel  <= 1'b1;
                        r_state <= S_DSET;
                    end
                end
                S_WB: begin
                    if (!r_ov || o_out_ch.ready) begin
                        r_ang_st[r_a]  <= r_ang;
                        r_bias_st[r_a] <= r_bias;
                        r_p00_st[r_a]  <= r_p00;
                        r_p01_st[r_a]  <= r_p01;
                        r_p10_st[r_a]  <= r_p10;
                        r_p11_st[r_a]  <= r_p11;
                        r_o_axis       <= r_axin;
                        r_o_ang        <= r_ang;
                        r_o_bias       <= r_bias;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/abkf_chk.sv]
// Port-level checks on the angle/bias Kalman filter, bound to its top level.
// Depends on abkf_pkg and the top level angle_bias_kalman_filter.
module abkf_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_out_axis,
    input logic signed [abkf_pkg::DATA_W-1:0] i_out_angle,
    input logic signed [abkf_pkg::DATA_W-1:0] i_out_bias
);
    import abkf_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> (!i_in_ready ##1 !i_in_ready))
        else $error("input taken while a beat is in work");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_axis) && $stable(i_out_angle)
             && $stable(i_out_bias)))
        else $error("stalled result beat changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("reset left a beat pending");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result beat without a beat in work");

endmodule

bind angle_bias_kalman_filter abkf_chk u_abkf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_axis  (o_out_ch.axis_out),
    .i_out_angle (o_out_ch.angle_estimate),
    .i_out_bias  (o_out_ch.bias_estimate)
);
